// ===== sv/cbsm_pkg.sv =====
// Shared types and constants for the ring buffer span manager.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none
package cbsm_pkg;

    localparam int MAX_CAPACITY = 65536;
    localparam int CAP_W        = $clog2(MAX_CAPACITY + 1);
    localparam int POS_W        = $clog2(MAX_CAPACITY);
    localparam int SUM_W        = CAP_W + 1;

    localparam logic [1:0] ACT_PREPARE = 2'd0;
    localparam logic [1:0] ACT_COMMIT  = 2'd1;
    localparam logic [1:0] ACT_CONSUME = 2'd2;

    typedef logic [CAP_W-1:0] t_len;
    typedef logic [POS_W-1:0] t_pos;
    typedef logic [SUM_W-1:0] t_sum;

    typedef struct packed {
        logic       valid;
        logic [1:0] action;
        t_len       amount;
    } t_item;

    typedef struct packed {
        logic length_error;
        t_pos read_start;
        t_len read_first_len;
        t_len read_second_len;
        t_pos write_start;
        t_len write_first_len;
        t_len write_second_len;
    } t_result;

endpackage
`default_nettype wire

// ===== sv/circular_buffer_span_manager_unit.sv =====
// Top level of the ring buffer span manager.
// Depends on cbsm_pkg, cbsm_in_stage, cbsm_ring_ctrl and cbsm_out_stage.
//
// Usage:
//   Command channel: drive start with action and amount; the item is taken
//   at a rising edge with start high and busy low. busy is high while reset
//   is applied and is cleared by the first clock edge after reset is released;
//   after that one item can be taken every cycle.
//   Result channel: o_result_valid pulses for one cycle with the result
//   fields after the item has passed the input register, then the state update
//   and span logic, then the result register. Items may follow back to back;
//   each sees the state left by the one before it.
//   The receiver cannot stall; a result is gone after its strobe cycle.
//   Configuration: i_cfg_we with i_cfg_wdata writes the capacity (zero acts
//   as one, above the maximum acts as the maximum) and clears the read
//   position, stored length and prepared size. Write only while idle.
//   Reset (i_rst_n low, synchronous): capacity returns to the maximum,
//   all counts clear and any item in flight is dropped.
`default_nettype none
module circular_buffer_span_manager_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_action,
    input  wire logic [16:0] i_amount,
    input  wire logic        i_cfg_we,
    input  wire logic [16:0] i_cfg_wdata,
    output logic             o_result_valid,
    output logic             o_length_error,
    output logic [15:0]      o_read_start,
    output logic [16:0]      o_read_first_len,
    output logic [16:0]      o_read_second_len,
    output logic [15:0]      o_write_start,
    output logic [16:0]      o_write_first_len,
    output logic [16:0]      o_write_second_len
);

    logic              r_busy;
    logic              accept;
    cbsm_pkg::t_item   item;
    cbsm_pkg::t_result core_result;
    cbsm_pkg::t_result out_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy   = r_busy;
    assign accept = start && !r_busy;

    cbsm_in_stage u_in (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_action (i_action),
        .i_amount (i_amount),
        .o_item   (item)
    );

    cbsm_ring_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (item),
        .o_result    (core_result)
    );

    cbsm_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (item.valid),
        .i_result (core_result),
        .o_valid  (o_result_valid),
        .o_result (out_result)
    );

    assign o_length_error     = out_result.length_error;
    assign o_read_start       = out_result.read_start;
    assign o_read_first_len   = out_result.read_first_len;
    assign o_read_second_len  = out_result.read_second_len;
    assign o_write_start      = out_result.write_start;
    assign o_write_first_len  = out_result.write_first_len;
    assign o_write_second_len = out_result.write_second_len;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_result_valid)
        else $error("accepted item produced no result two cycles later");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (item.valid && !$past(accept)) |-> 1'b0)
        else $error("input stage holds an item that was never accepted");

    a_err_no_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_length_error) |->
            (o_write_start == '0 && o_write_first_len == '0 && o_write_second_len == '0))
        else $error("rejected prepare reported a write span");

    a_wrap_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_read_second_len != '0) |->
            (17'(o_read_start) + o_read_first_len == 17'(cbsm_pkg::MAX_CAPACITY)
             || o_read_first_len != '0))
        else $error("wrapped read span without a first span");

endmodule
`default_nettype wire

// ===== sv/cbsm_in_stage.sv =====
// Input register of the ring buffer span manager.
// Depends on cbsm_pkg for the item type.
`default_nettype none
module cbsm_in_stage (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_accept,
    input  wire logic [1:0]     i_action,
    input  wire cbsm_pkg::t_len i_amount,
    output cbsm_pkg::t_item     o_item
);

    logic            r_valid;
    logic [1:0]      r_action;
    cbsm_pkg::t_len  r_amount;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_action <= i_action;
            r_amount <= i_amount;
        end
    end

    assign o_item = '{valid: r_valid, action: r_action, amount: r_amount};

endmodule
`default_nettype wire

// ===== sv/cbsm_ring_ctrl.sv =====
// Ring state registers (capacity, read position, stored and prepared sizes)
// and the single-pass update and span logic. Depends on cbsm_pkg.
`default_nettype none
module cbsm_ring_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire cbsm_pkg::t_len  i_cfg_wdata,
    input  wire cbsm_pkg::t_item i_item,
    output cbsm_pkg::t_result    o_result
);

    cbsm_pkg::t_len r_cap;
    cbsm_pkg::t_pos r_rp;
    cbsm_pkg::t_len r_sl;
    cbsm_pkg::t_len r_ps;

    cbsm_pkg::t_len n_cap;
    cbsm_pkg::t_pos n_rp;
    cbsm_pkg::t_len n_sl;
    cbsm_pkg::t_len n_ps;

    cbsm_pkg::t_sum wpos_sum;
    cbsm_pkg::t_pos wpos;
    cbsm_pkg::t_len free_len;
    cbsm_pkg::t_sum cons_sum;
    cbsm_pkg::t_pos cons_pos;
    cbsm_pkg::t_sum wend;
    cbsm_pkg::t_sum rend;
    cbsm_pkg::t_len commit_len;
    cbsm_pkg::t_len amount;
    cbsm_pkg::t_len r1;
    logic           err;
    cbsm_pkg::t_pos ws;
    cbsm_pkg::t_len w1;
    cbsm_pkg::t_len w2;

    assign amount = i_item.amount;

    always_comb begin
        if (i_cfg_wdata == '0) begin
            n_cap = cbsm_pkg::t_len'(1);
        end else if (i_cfg_wdata > cbsm_pkg::t_len'(cbsm_pkg::MAX_CAPACITY)) begin
            n_cap = cbsm_pkg::t_len'(cbsm_pkg::MAX_CAPACITY);
        end else begin
            n_cap = i_cfg_wdata;
        end
    end

    always_comb begin
        wpos_sum   = cbsm_pkg::t_sum'(r_rp) + cbsm_pkg::t_sum'(r_sl);
        wpos       = (wpos_sum >= cbsm_pkg::t_sum'(r_cap))
                   ? cbsm_pkg::t_pos'(wpos_sum - cbsm_pkg::t_sum'(r_cap))
                   : cbsm_pkg::t_pos'(wpos_sum);
        free_len   = r_cap - r_sl;
        cons_sum   = cbsm_pkg::t_sum'(r_rp) + cbsm_pkg::t_sum'(amount);
        cons_pos   = (cons_sum >= cbsm_pkg::t_sum'(r_cap))
                   ? cbsm_pkg::t_pos'(cons_sum - cbsm_pkg::t_sum'(r_cap))
                   : cbsm_pkg::t_pos'(cons_sum);
        wend       = cbsm_pkg::t_sum'(wpos) + cbsm_pkg::t_sum'(amount);
        commit_len = (amount < r_ps) ? amount : r_ps;

        n_rp = r_rp;
        n_sl = r_sl;
        n_ps = r_ps;
        err  = 1'b0;
        ws   = '0;
        w1   = '0;
        w2   = '0;

        case (i_item.action)
            cbsm_pkg::ACT_PREPARE: begin
                if (amount > free_len) begin
                    err = 1'b1;
                end else begin
                    n_ps = amount;
                    ws   = wpos;
                    if (wend <= cbsm_pkg::t_sum'(r_cap)) begin
                        w1 = amount;
                    end else begin
                        w1 = r_cap - cbsm_pkg::t_len'(wpos);
                        w2 = amount - w1;
                    end
                end
            end
            cbsm_pkg::ACT_COMMIT: begin
                n_sl = r_sl + commit_len;
                n_ps = '0;
            end
            cbsm_pkg::ACT_CONSUME: begin
                if (amount < r_sl) begin
                    n_rp = cons_pos;
                    n_sl = r_sl - amount;
                end else begin
                    n_rp = (r_ps != '0) ? wpos : '0;
                    n_sl = '0;
                end
            end
            default: begin
            end
        endcase

        rend = cbsm_pkg::t_sum'(n_rp) + cbsm_pkg::t_sum'(n_sl);
        r1   = r_cap - cbsm_pkg::t_len'(n_rp);

        o_result.length_error     = err;
        o_result.read_start       = n_rp;
        o_result.write_start      = ws;
        o_result.write_first_len  = w1;
        o_result.write_second_len = w2;
        if (rend <= cbsm_pkg::t_sum'(r_cap)) begin
            o_result.read_first_len  = n_sl;
            o_result.read_second_len = '0;
        end else begin
            o_result.read_first_len  = r1;
            o_result.read_second_len = n_sl - r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= cbsm_pkg::t_len'(cbsm_pkg::MAX_CAPACITY);
            r_rp  <= '0;
            r_sl  <= '0;
            r_ps  <= '0;
        end else if (i_cfg_we) begin
            r_cap <= n_cap;
            r_rp  <= '0;
            r_sl  <= '0;
            r_ps  <= '0;
        end else if (i_item.valid) begin
            r_rp  <= n_rp;
            r_sl  <= n_sl;
            r_ps  <= n_ps;
        end
    end

endmodule
`default_nettype wire

// ===== sv/cbsm_out_stage.sv =====
// Result register and strobe of the ring buffer span manager.
// Depends on cbsm_pkg for the result type.
`default_nettype none
module cbsm_out_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire cbsm_pkg::t_result i_result,
    output logic                   o_valid,
    output cbsm_pkg::t_result      o_result
);

    logic              r_valid;
    cbsm_pkg::t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
`default_nettype wire

// ===== tb/tb_circular_buffer_span_manager_unit.sv =====
// Self-checking testbench for circular_buffer_span_manager_unit.
// Depends on cbsm_pkg; a ring model predicts every result item and a monitor
// compares it with the DUT while capacity is swept across phases.
`default_nettype none
module tb_circular_buffer_span_manager_unit;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 4;

    typedef struct {
        logic           hold;
        logic [1:0]     act;
        cbsm_pkg::t_len amt;
    } t_ring_op;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           start = 1'b0;
    logic [1:0]     i_action = cbsm_pkg::ACT_COMMIT;
    cbsm_pkg::t_len i_amount = '0;
    logic           i_cfg_we = 1'b0;
    logic [16:0]    i_cfg_wdata = '0;
    wire            busy;
    wire            o_result_valid;
    wire            o_length_error;
    wire [15:0]     o_read_start;
    wire [16:0]     o_read_first_len;
    wire [16:0]     o_read_second_len;
    wire [15:0]     o_write_start;
    wire [16:0]     o_write_first_len;
    wire [16:0]     o_write_second_len;

    t_ring_op          pend_q[$];
    cbsm_pkg::t_result span_q[$];
    t_ring_op          next_op;
    cbsm_pkg::t_result got_res;
    cbsm_pkg::t_result want_res;
    logic              item_taken = 1'b0;
    int                idle_pct = 37;
    int                cycle_cnt = 0;
    int                fault_cnt = 0;

    int unsigned cap_reg = cbsm_pkg::MAX_CAPACITY;
    int unsigned rd_pos = 0;
    int unsigned held_len = 0;
    int unsigned prep_len = 0;

    circular_buffer_span_manager_unit u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_action           (i_action),
        .i_amount           (i_amount),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .o_result_valid     (o_result_valid),
        .o_length_error     (o_length_error),
        .o_read_start       (o_read_start),
        .o_read_first_len   (o_read_first_len),
        .o_read_second_len  (o_read_second_len),
        .o_write_start      (o_write_start),
        .o_write_first_len  (o_write_first_len),
        .o_write_second_len (o_write_second_len)
    );

    always #6 i_clk = ~i_clk;

    function automatic int unsigned ring_cap(int unsigned raw);
        if (raw == 0) return 1;
        if (raw > cbsm_pkg::MAX_CAPACITY) return cbsm_pkg::MAX_CAPACITY;
        return raw;
    endfunction

    function automatic cbsm_pkg::t_result advance_ring(logic [1:0] act, cbsm_pkg::t_len n);
        cbsm_pkg::t_result r;
        int unsigned       cap;
        int unsigned       nn;
        int unsigned       pos;
        int unsigned       span1;
        r = '0;
        cap = ring_cap(cap_reg);
        nn = n;
        case (act)
            cbsm_pkg::ACT_PREPARE: begin
                if (nn > cap - held_len) begin
                    r.length_error = 1'b1;
                end else begin
                    pos = rd_pos + held_len;
                    if (pos >= cap) pos -= cap;
                    prep_len = nn;
                    r.write_start = cbsm_pkg::t_pos'(pos);
                    if (pos + nn <= cap) begin
                        r.write_first_len = cbsm_pkg::t_len'(nn);
                    end else begin
                        span1 = cap - pos;
                        r.write_first_len = cbsm_pkg::t_len'(span1);
                        r.write_second_len = cbsm_pkg::t_len'(nn - span1);
                    end
                end
            end
            cbsm_pkg::ACT_COMMIT: begin
                held_len += (nn < prep_len) ? nn : prep_len;
                prep_len = 0;
            end
            cbsm_pkg::ACT_CONSUME: begin
                if (nn < held_len) begin
                    rd_pos += nn;
                    if (rd_pos >= cap) rd_pos -= cap;
                    held_len -= nn;
                end else begin
                    if (prep_len != 0) begin
                        rd_pos += held_len;
                        if (rd_pos >= cap) rd_pos -= cap;
                    end else begin
                        rd_pos = 0;
                    end
                    held_len = 0;
                end
            end
            default: ;
        endcase
        r.read_start = cbsm_pkg::t_pos'(rd_pos);
        if (rd_pos + held_len <= cap) begin
            r.read_first_len = cbsm_pkg::t_len'(held_len);
        end else begin
            r.read_first_len = cbsm_pkg::t_len'(cap - rd_pos);
            r.read_second_len = cbsm_pkg::t_len'(held_len - (cap - rd_pos));
        end
        return r;
    endfunction

    task automatic log_fault(string what, cbsm_pkg::t_result want,
                             cbsm_pkg::t_result got);
        fault_cnt++;
        if (fault_cnt <= 10) begin
            $write("[%0d] %s: exp err=%0b rs=%0d r1=%0d r2=%0d ws=%0d w1=%0d w2=%0d",
                   cycle_cnt, what,
                   want.length_error, want.read_start, want.read_first_len,
                   want.read_second_len, want.write_start, want.write_first_len,
                   want.write_second_len);
            $display(" | got err=%0b rs=%0d r1=%0d r2=%0d ws=%0d w1=%0d w2=%0d",
                     got.length_error, got.read_start, got.read_first_len,
                     got.read_second_len, got.write_start, got.write_first_len,
                     got.write_second_len);
        end
    endtask

    // Predict on acceptance, check on strobe.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (!i_rst_n) begin
            cap_reg = cbsm_pkg::MAX_CAPACITY;
            rd_pos = 0;
            held_len = 0;
            prep_len = 0;
            span_q.delete();
            item_taken <= 1'b0;
        end else begin
            if (o_result_valid) begin
                got_res.length_error     = o_length_error;
                got_res.read_start       = o_read_start;
                got_res.read_first_len   = o_read_first_len;
                got_res.read_second_len  = o_read_second_len;
                got_res.write_start      = o_write_start;
                got_res.write_first_len  = o_write_first_len;
                got_res.write_second_len = o_write_second_len;
                if (span_q.size() == 0) begin
                    log_fault("unexpected result", '0, got_res);
                end else begin
                    want_res = span_q.pop_front();
                    if (got_res.length_error !== want_res.length_error ||
                        got_res.read_start !== want_res.read_start ||
                        got_res.read_first_len !== want_res.read_first_len ||
                        got_res.read_second_len !== want_res.read_second_len ||
                        got_res.write_start !== want_res.write_start ||
                        got_res.write_first_len !== want_res.write_first_len ||
                        got_res.write_second_len !== want_res.write_second_len)
                        log_fault("mismatch", want_res, got_res);
                end
            end
            if (i_cfg_we) begin
                cap_reg = i_cfg_wdata;
                rd_pos = 0;
                held_len = 0;
                prep_len = 0;
            end
            item_taken <= start && !busy;
            if (start && !busy)
                span_q.push_back(advance_ring(i_action, i_amount));
        end
    end

    // Feed items from the pending queue; a hold entry waits until no results are outstanding.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || item_taken) begin
            if (pend_q.size() == 0 || $urandom_range(0, 99) < idle_pct) begin
                start <= 1'b0;
            end else if (pend_q[0].hold) begin
                if (span_q.size() == 0 && !start)
                    void'(pend_q.pop_front());
                start <= 1'b0;
            end else begin
                next_op = pend_q.pop_front();
                start <= 1'b1;
                i_action <= next_op.act;
                i_amount <= next_op.amt;
            end
        end
    end

    task automatic push_op(logic [1:0] act, cbsm_pkg::t_len amt);
        t_ring_op op;
        op.hold = 1'b0;
        op.act = act;
        op.amt = amt;
        pend_q.push_back(op);
    endtask

    task automatic push_hold();
        t_ring_op op;
        op.hold = 1'b1;
        op.act = cbsm_pkg::ACT_COMMIT;
        op.amt = '0;
        pend_q.push_back(op);
    endtask

    function automatic cbsm_pkg::t_len pick_amount(int unsigned cap);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8) return '0;
        if (r < 16) return cbsm_pkg::t_len'(cap);
        if (r < 22) return cbsm_pkg::t_len'($urandom);
        if (r < 60) return cbsm_pkg::t_len'($urandom_range(1, (cap < 8) ? cap : 8));
        return cbsm_pkg::t_len'($urandom_range(1, cap / 3 + 1));
    endfunction

    // Mostly prepare/commit/consume sequences, the rest raw noise.
    task automatic push_random_ops(int unsigned cap, int n_items);
        int             cnt;
        int unsigned    r;
        cbsm_pkg::t_len p;
        logic [1:0]     act;
        cnt = 0;
        while (cnt < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                p = pick_amount(cap);
                push_op(cbsm_pkg::ACT_PREPARE, p);
                cnt++;
                r = $urandom_range(0, 99);
                if (r < 85) begin
                    push_op(cbsm_pkg::ACT_COMMIT, (r < 50) ? p : pick_amount(cap));
                    cnt++;
                end
                if ($urandom_range(0, 1) == 1) begin
                    push_op(cbsm_pkg::ACT_CONSUME, pick_amount(cap));
                    cnt++;
                end
            end else begin
                act = 2'($urandom_range(0, 3));
                push_op(act, ($urandom_range(0, 1) == 1)
                             ? cbsm_pkg::t_len'($urandom) : pick_amount(cap));
                if (act != 2'd3) cnt++;
            end
        end
    endtask

    task automatic wait_drained();
        while (pend_q.size() != 0 || start || span_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [16:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) @(posedge i_clk);
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        logic [16:0] caps[11];
        logic [16:0] c;
        caps = '{17'd1, 17'd0, 17'd2, 17'd5, 17'd16, 17'd100, 17'd4096,
                 17'd65535, 17'h10000, 17'h1FFFF, 17'd0};
        caps[10] = 17'($urandom_range(1, 65536));

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pass at full capacity.
        push_op(cbsm_pkg::ACT_PREPARE, 17'd0);
        push_op(cbsm_pkg::ACT_PREPARE, 17'h10000);
        push_op(cbsm_pkg::ACT_COMMIT, 17'h10000);
        push_op(cbsm_pkg::ACT_PREPARE, 17'd1);
        push_op(cbsm_pkg::ACT_CONSUME, 17'd100);
        push_op(cbsm_pkg::ACT_PREPARE, 17'd100);
        push_op(cbsm_pkg::ACT_COMMIT, 17'd50);
        push_op(cbsm_pkg::ACT_CONSUME, 17'h10000);
        push_hold();
        push_op(cbsm_pkg::ACT_PREPARE, 17'd60000);
        push_op(cbsm_pkg::ACT_COMMIT, 17'd70000);
        push_op(cbsm_pkg::ACT_CONSUME, 17'd50000);
        push_op(cbsm_pkg::ACT_PREPARE, 17'd20000);
        push_op(cbsm_pkg::ACT_COMMIT, 17'd20000);
        push_op(cbsm_pkg::ACT_PREPARE, 17'd10);
        push_op(cbsm_pkg::ACT_CONSUME, 17'h1FFFF);
        push_op(cbsm_pkg::ACT_COMMIT, 17'd10);
        push_op(2'd3, 17'h1FFFF);
        push_op(cbsm_pkg::ACT_COMMIT, 17'd5);
        push_op(cbsm_pkg::ACT_CONSUME, 17'd0);
        push_op(cbsm_pkg::ACT_PREPARE, 17'h10001);
        push_random_ops(cbsm_pkg::MAX_CAPACITY, 150);
        wait_drained();

        foreach (caps[i]) begin
            c = caps[i];
            idle_pct = (i == 8) ? 0 : 37;
            write_capacity(c);
            push_random_ops(ring_cap(c), 75);
            push_hold();
            push_random_ops(ring_cap(c), 75);
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        while (span_q.size() != 0)
            log_fault("missing result", span_q.pop_front(), '0);
        if (fault_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
`default_nettype wire
